/* hw/rtl/trf_pkg.sv */
// Shared types, constants and register codes of the threshold region finder.
package trf_pkg;

   // Default waveform length limit.
   localparam int MAX_SAMPLES_DEF = 65536;

   // Fixed field widths.
   localparam int SAMPLE_W = 16;
   localparam int THRESH_W = 15;
   localparam int PAD_W    = 8;
   localparam int START_W  = 16;
   localparam int STOP_W   = 17;
   localparam int COUNT_W  = 17;

   // Result slots per input item.
   localparam int SLOTS   = 3;
   localparam int SLOT_W  = 2;

   // Bundle queue between front and back.
   localparam int QUEUE_DEPTH = 2;

   // Register port.
   localparam int ADDR_W = 3;
   localparam int DATA_W = 32;
   localparam logic REG_THRESHOLD = 1'b0;
   localparam logic REG_PAD       = 1'b1;
   localparam logic [THRESH_W-1:0] THRESHOLD_RESET = 15'd100;
   localparam logic [PAD_W-1:0]    PAD_RESET       = 8'd1;

   // Result kinds.
   localparam logic KIND_REGION  = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       last;
   } req_type;

   typedef struct packed {
      logic               kind;
      logic [START_W-1:0] start_res;
      logic [STOP_W-1:0]  stop;
      logic [COUNT_W-1:0] below_total;
      logic               final_res;
   } rsp_type;

   // All results caused by one input item.
   typedef struct packed {
      rsp_type [SLOTS-1:0] res;
      logic [SLOT_W-1:0]   n_items;
   } bundle_type;

   // Queue status seen by the front and the back.
   typedef struct packed {
      logic full;
      logic not_empty;
   } queue_status_type;

endpackage

/* hw/rtl/trf_front.sv */
// Front end: classifies samples, tracks open and held regions, builds result bundles.
module trf_front #(
   parameter int MAX_SAMPLES = trf_pkg::MAX_SAMPLES_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  trf_pkg::req_type                 req_data,
   output logic                             req_ready,
   input  logic [trf_pkg::THRESH_W-1:0]     threshold,
   input  logic [trf_pkg::PAD_W-1:0]        pad,
   input  trf_pkg::queue_status_type        q_status,
   output logic                             push,
   output trf_pkg::bundle_type              bundle
);

   localparam int IW = $clog2(MAX_SAMPLES);
   localparam int SW = ((IW > trf_pkg::PAD_W) ? IW : trf_pkg::PAD_W) + 1;
   localparam int CW = SW + 1;
   localparam logic [IW-1:0] LAST_INDEX = IW'(MAX_SAMPLES - 1);

   logic [IW-1:0]                index_ff, index_in;
   logic                         in_region_ff, in_region_in;
   logic [IW-1:0]                open_start_ff, open_start_in;
   logic                         held_valid_ff, held_valid_in;
   logic [IW-1:0]                held_start_ff, held_start_in;
   logic [SW-1:0]                held_stop_ff, held_stop_in;
   logic [trf_pkg::COUNT_W-1:0]  below_count_ff, below_count_in;

   logic                         accept;
   logic [CW-1:0]                i_c, pad_c, len_c, cand_c, close_end;
   logic [CW-1:0]                os, hs, hp;
   logic                         ir, hv;
   logic [trf_pkg::SLOT_W-1:0]   n;
   logic [trf_pkg::COUNT_W-1:0]  cnt;
   logic signed [trf_pkg::SAMPLE_W:0] sample_x, limit;
   logic                         is_below, is_last;

   // Region result with its stop clamped to the length so far.
   function automatic trf_pkg::rsp_type region_item(
      input logic [CW-1:0] start_c,
      input logic [CW-1:0] stop_c,
      input logic [CW-1:0] len_v
   );
      trf_pkg::rsp_type r;
      r.kind        = trf_pkg::KIND_REGION;
      r.start_res   = trf_pkg::START_W'(start_c);
      r.stop        = (stop_c < len_v) ? trf_pkg::STOP_W'(stop_c) : trf_pkg::STOP_W'(len_v);
      r.below_total = '0;
      r.final_res   = 1'b0;
      return r;
   endfunction

   assign req_ready = !q_status.full;
   assign accept    = req_valid && req_ready;

   // Classify the sample and work out every result it causes.
   always_comb begin
      i_c       = CW'(index_ff);
      pad_c     = CW'(pad);
      len_c     = i_c + CW'(1);
      cand_c    = (i_c > pad_c) ? (i_c - pad_c) : '0;
      close_end = i_c + pad_c;
      sample_x  = {req_data.sample[trf_pkg::SAMPLE_W-1], req_data.sample};
      limit     = -$signed({2'b00, threshold});
      is_below  = sample_x < limit;
      is_last   = req_data.last || (index_ff == LAST_INDEX);

      ir     = in_region_ff;
      os     = CW'(open_start_ff);
      hv     = held_valid_ff;
      hs     = CW'(held_start_ff);
      hp     = CW'(held_stop_ff);
      n      = '0;
      bundle = '0;
      cnt    = below_count_ff;

      // Release the held region when nothing from here on can join it.
      if (!ir && hv && (cand_c > hp + pad_c)) begin
         bundle.res[n] = region_item(hs, hp, len_c);
         n  = n + 2'd1;
         hv = 1'b0;
      end

      // Open, extend or close the current region.
      if (is_below) begin
         if (!ir) begin
            os = cand_c;
            ir = 1'b1;
         end
         if (cnt != '1) begin
            cnt = cnt + trf_pkg::COUNT_W'(1);
         end
      end else if (ir) begin
         if (hv && (os <= hp + pad_c)) begin
            hp = close_end;
         end else begin
            if (hv) begin
               bundle.res[n] = region_item(hs, hp, len_c);
               n = n + 2'd1;
            end
            hv = 1'b1;
            hs = os;
            hp = close_end;
         end
         ir = 1'b0;
      end

      // Close out the waveform: final region, held region, summary.
      if (is_last) begin
         if (ir) begin
            if (hv && (os <= hp + pad_c)) begin
               hp = len_c;
            end else begin
               if (hv) begin
                  bundle.res[n] = region_item(hs, hp, len_c);
                  n = n + 2'd1;
               end
               hv = 1'b1;
               hs = os;
               hp = len_c;
            end
            ir = 1'b0;
         end
         if (hv) begin
            bundle.res[n] = region_item(hs, hp, len_c);
            n = n + 2'd1;
         end
         bundle.res[n].kind        = trf_pkg::KIND_SUMMARY;
         bundle.res[n].start_res   = '0;
         bundle.res[n].stop        = '0;
         bundle.res[n].below_total = cnt;
         bundle.res[n].final_res   = 1'b1;
         n = n + 2'd1;
      end
      bundle.n_items = n;
      push           = accept && (n != '0);

      // Next state; clear everything at the end of a waveform.
      if (is_last) begin
         index_in       = '0;
         in_region_in   = 1'b0;
         open_start_in  = '0;
         held_valid_in  = 1'b0;
         held_start_in  = '0;
         held_stop_in   = '0;
         below_count_in = '0;
      end else begin
         index_in       = index_ff + IW'(1);
         in_region_in   = ir;
         open_start_in  = IW'(os);
         held_valid_in  = hv;
         held_start_in  = IW'(hs);
         held_stop_in   = SW'(hp);
         below_count_in = cnt;
      end
   end

   // Advance the waveform state on each accepted item.
   always_ff @(posedge clock) begin
      if (reset) begin
         index_ff       <= '0;
         in_region_ff   <= 1'b0;
         open_start_ff  <= '0;
         held_valid_ff  <= 1'b0;
         held_start_ff  <= '0;
         held_stop_ff   <= '0;
         below_count_ff <= '0;
      end else if (accept) begin
         index_ff       <= index_in;
         in_region_ff   <= in_region_in;
         open_start_ff  <= open_start_in;
         held_valid_ff  <= held_valid_in;
         held_start_ff  <= held_start_in;
         held_stop_ff   <= held_stop_in;
         below_count_ff <= below_count_in;
      end
   end

endmodule

/* hw/rtl/trf_queue.sv */
// Short queue of result bundles between the front and the back.
module trf_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  trf_pkg::bundle_type        push_bundle,
   input  logic                       pop,
   output trf_pkg::bundle_type        head,
   output trf_pkg::queue_status_type  status
);

   localparam int PTR_W = (trf_pkg::QUEUE_DEPTH > 1) ? $clog2(trf_pkg::QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(trf_pkg::QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(trf_pkg::QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(trf_pkg::QUEUE_DEPTH);

   trf_pkg::bundle_type entry_ff [trf_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign status.full      = (count_ff == FULL_CNT);
   assign status.not_empty = (count_ff != '0);
   assign head             = entry_ff[rd_ptr_ff];
   assign do_push          = push && !status.full;
   assign do_pop           = pop && status.not_empty;

   // Wrap the pointers and track the fill level.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (!do_push && do_pop) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the incoming bundle.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_bundle;
      end
   end

endmodule

/* hw/rtl/trf_back.sv */
// Back end: unpacks queued bundles into single results behind an output register.
module trf_back (
   input  logic                       clock,
   input  logic                       reset,
   input  trf_pkg::bundle_type        head,
   input  trf_pkg::queue_status_type  q_status,
   output logic                       pop,
   output logic                       rsp_valid,
   output trf_pkg::rsp_type           rsp_data,
   input  logic                       rsp_ready
);

   logic [trf_pkg::SLOT_W-1:0] slot_ff, slot_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   trf_pkg::rsp_type           rsp_data_ff, rsp_data_in;
   logic                       load, last_slot;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Load the next slot whenever the output register is free or draining.
   always_comb begin
      load         = q_status.not_empty && (!rsp_valid_ff || rsp_ready);
      last_slot    = (slot_ff == (head.n_items - trf_pkg::SLOT_W'(1)));
      pop          = load && last_slot;
      slot_in      = slot_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (load) begin
         slot_in      = last_slot ? '0 : slot_ff + trf_pkg::SLOT_W'(1);
         rsp_valid_in = 1'b1;
         rsp_data_in  = head.res[slot_ff];
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         slot_ff      <= slot_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold the result until it is taken.
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

endmodule

/* hw/rtl/threshold_region_finder_top.sv */
// Threshold region finder: the top level with its register port.
// Accepts one signed sample per clock and reports padded regions where the
// sample falls below minus the threshold, merging regions that lie within the
// pad distance, then a summary item with the count of crossing samples at the
// end of each waveform. Each sample produces zero to three results, which
// leave through the result channel at one per clock while it is ready, from
// a two-bundle queue through the output register. Samples keep arriving at
// one per clock as long as results drain at least as fast as they are made;
// a sample that causes two or three results keeps its bundle queued until
// all of them have been offered. Waveforms longer than MAX_SAMPLES are cut
// at MAX_SAMPLES samples. Threshold (address 0) and pad (address 4) should
// be written only while the block is idle.
module threshold_region_finder_top #(
   parameter int MAX_SAMPLES = trf_pkg::MAX_SAMPLES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  trf_pkg::req_type              req_data,
   output logic                          req_ready,
   output logic                          rsp_valid,
   output trf_pkg::rsp_type              rsp_data,
   input  logic                          rsp_ready,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [trf_pkg::ADDR_W-1:0]    csr_paddr,
   input  logic [trf_pkg::DATA_W-1:0]    csr_pwdata,
   output logic [trf_pkg::DATA_W-1:0]    csr_prdata,
   output logic                          csr_pready
);

   logic [trf_pkg::THRESH_W-1:0] threshold_ff;
   logic [trf_pkg::PAD_W-1:0]    pad_ff;
   logic                         csr_write;
   logic                         reg_sel;

   trf_pkg::queue_status_type    q_status;
   trf_pkg::bundle_type          push_bundle;
   trf_pkg::bundle_type          head;
   logic                         push;
   logic                         pop;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_sel    = csr_paddr[2];

   // Write the configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= trf_pkg::THRESHOLD_RESET;
         pad_ff       <= trf_pkg::PAD_RESET;
      end else if (csr_write) begin
         unique case (reg_sel)
            trf_pkg::REG_THRESHOLD: threshold_ff <= csr_pwdata[trf_pkg::THRESH_W-1:0];
            trf_pkg::REG_PAD:       pad_ff       <= csr_pwdata[trf_pkg::PAD_W-1:0];
            default:                threshold_ff <= threshold_ff;
         endcase
      end
   end

   // Read back the selected register.
   always_comb begin
      unique case (reg_sel)
         trf_pkg::REG_THRESHOLD: csr_prdata = trf_pkg::DATA_W'(threshold_ff);
         trf_pkg::REG_PAD:       csr_prdata = trf_pkg::DATA_W'(pad_ff);
         default:                csr_prdata = '0;
      endcase
   end

   trf_front #(
      .MAX_SAMPLES(MAX_SAMPLES)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .req_ready (req_ready),
      .threshold (threshold_ff),
      .pad       (pad_ff),
      .q_status  (q_status),
      .push      (push),
      .bundle    (push_bundle)
   );

   trf_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .push_bundle (push_bundle),
      .pop         (pop),
      .head        (head),
      .status      (q_status)
   );

   trf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .q_status  (q_status),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .rsp_ready (rsp_ready)
   );

endmodule

/* hw/rtl/trf_checker.sv */
// Port-level checks of the threshold region finder and their binding.
module trf_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  trf_pkg::req_type              req_data,
   input  logic                          req_ready,
   input  logic                          rsp_valid,
   input  trf_pkg::rsp_type              rsp_data,
   input  logic                          rsp_ready,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [trf_pkg::ADDR_W-1:0]    csr_paddr,
   input  logic [trf_pkg::DATA_W-1:0]    csr_pwdata,
   input  logic [trf_pkg::DATA_W-1:0]    csr_prdata,
   input  logic                          csr_pready
);

   logic thr_write;

   assign thr_write = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                      (csr_paddr[2] == trf_pkg::REG_THRESHOLD);

   // A waiting input item stays unchanged until taken.
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_data))
      else $error("input item changed while waiting");

   // A stalled result holds its item.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result item changed while stalled");

   // Leaving reset: input ready, nothing offered.
   a_reset_clean: assert property (@(posedge clock)
      $past(reset) && !reset |-> req_ready && !rsp_valid)
      else $error("block not clean after reset");

   // A threshold write reads back on the next cycle.
   a_thr_readback: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && $past(thr_write) && (csr_paddr[2] == trf_pkg::REG_THRESHOLD)
      |-> csr_prdata == trf_pkg::DATA_W'($past(csr_pwdata[trf_pkg::THRESH_W-1:0])))
      else $error("threshold readback mismatch");

   // Region items are non-empty and never marked final.
   a_region_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.kind == trf_pkg::KIND_REGION)
      |-> (trf_pkg::STOP_W'(rsp_data.start_res) < rsp_data.stop) && !rsp_data.final_res)
      else $error("malformed region item");

endmodule

bind threshold_region_finder_top trf_checker u_checker (.*);
